// ===== hdl/icmp_erc_pkg.sv =====
// Types, constants and helper functions of the ICMP echo reply checker.
// Used by the checker top level and its assertion checker; no dependencies.
`default_nettype none

package icmp_erc_pkg;

    localparam int unsigned MAX_BYTES_DEF = 2048;

    localparam logic [15:0] POS_IHL     = 16'd0;
    localparam logic [15:0] POS_TLEN_HI = 16'd2;
    localparam logic [15:0] POS_TLEN_LO = 16'd3;
    localparam logic [15:0] POS_TTL     = 16'd8;

    localparam logic [15:0] OFF_TYPE    = 16'd0;
    localparam logic [15:0] OFF_ID_HI   = 16'd4;
    localparam logic [15:0] OFF_ID_LO   = 16'd5;
    localparam logic [15:0] OFF_SEQ_HI  = 16'd6;
    localparam logic [15:0] OFF_SEQ_LO  = 16'd7;

    localparam logic [5:0]  HDR_MIN     = 6'd20;
    localparam logic [16:0] ICMP_MIN_LEN = 17'd8;
    localparam logic [7:0]  TYPE_REPLY  = 8'd0;
    localparam logic [15:0] CSUM_GOOD   = 16'hffff;
    localparam logic [11:0] ILEN_MAX    = 12'hfff;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_REPLY = 3'd1,
        ST_ID_BAD    = 3'd2,
        ST_CSUM_BAD  = 3'd3,
        ST_MALFORMED = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [15:0] sequence_res;
        logic [7:0]  ttl;
        logic [11:0] icmp_length;
    } t_out_beat;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/icmp_echo_reply_checker.sv =====
// ICMP echo reply checker: parses an IPv4 packet byte by byte and gives one verdict per packet.
// Depends on icmp_erc_pkg.
// Throughput: one beat per cycle while not stalled; input register, then parse/checksum logic, then result register.
// Backpressure: input stalls only while a result is held and the output is stalled.
// Reset: synchronous active low; clears packet state, pipeline valids and expected_id.
`default_nettype none

module icmp_echo_reply_checker #(
    parameter int unsigned MAX_BYTES = icmp_erc_pkg::MAX_BYTES_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  icmp_erc_pkg::t_in_beat   i_in_beat,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output icmp_erc_pkg::t_out_beat  o_out_beat,
    input  wire                      i_cfg_we,
    input  wire [15:0]               i_cfg_data
);
    import icmp_erc_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_BYTES + 1);

    logic             r_in_valid;
    t_in_beat         r_in;
    logic             r_out_valid;
    t_out_beat        r_out;
    logic [15:0]      r_expected_id;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [5:0]       r_hdr, n_hdr;
    logic [15:0]      r_plen, n_plen;
    logic [7:0]       r_ttl, n_ttl;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_id, n_id;
    logic [15:0]      r_seq, n_seq;
    logic [15:0]      r_sum, n_sum;
    logic [7:0]       r_hold, n_hold;
    logic             r_too_long, n_too_long;

    logic             w_adv;
    logic             w_proc;
    logic [15:0]      w_pos16;
    logic [15:0]      w_off;
    logic [15:0]      w_ilen;
    logic [15:0]      w_sum_fin;
    logic             w_malformed;
    t_out_beat        w_res;

    assign w_adv       = !(r_out_valid && i_out_stall);
    assign w_proc      = r_in_valid && w_adv;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign w_pos16     = 16'(r_pos);

    // parse and sum one byte
    always_comb begin
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_plen     = r_plen;
        n_ttl      = r_ttl;
        n_type     = r_type;
        n_id       = r_id;
        n_seq      = r_seq;
        n_sum      = r_sum;
        n_hold     = r_hold;
        n_too_long = r_too_long;
        w_off      = 16'd0;
        if (r_pos < POS_W'(MAX_BYTES)) begin
            case (w_pos16)
                POS_IHL:     n_hdr  = {r_in.data_byte[3:0], 2'b00};
                POS_TLEN_HI: n_plen = {r_in.data_byte, r_plen[7:0]};
                POS_TLEN_LO: n_plen = {r_plen[15:8], r_in.data_byte};
                POS_TTL:     n_ttl  = r_in.data_byte;
                default:     ;
            endcase
            w_off = w_pos16 - {10'd0, n_hdr};
            if (w_pos16 >= {10'd0, n_hdr} && w_pos16 < n_plen) begin
                case (w_off)
                    OFF_TYPE:   n_type = r_in.data_byte;
                    OFF_ID_HI:  n_id   = {r_in.data_byte, r_id[7:0]};
                    OFF_ID_LO:  n_id   = {r_id[15:8], r_in.data_byte};
                    OFF_SEQ_HI: n_seq  = {r_in.data_byte, r_seq[7:0]};
                    OFF_SEQ_LO: n_seq  = {r_seq[15:8], r_in.data_byte};
                    default:    ;
                endcase
                if (!w_off[0]) begin
                    n_hold = r_in.data_byte;
                end else begin
                    n_sum = oc_add(r_sum, {r_hold, r_in.data_byte});
                end
            end
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_too_long = 1'b1;
        end
    end

    // verdict on the packet state after this byte
    always_comb begin
        w_ilen = (n_plen >= {10'd0, n_hdr}) ? (n_plen - {10'd0, n_hdr}) : 16'd0;
        w_sum_fin = w_ilen[0] ? oc_add(n_sum, {n_hold, 8'd0}) : n_sum;
        w_malformed = n_too_long || (n_hdr < HDR_MIN)
                   || ({1'b0, n_plen} < ({11'd0, n_hdr} + ICMP_MIN_LEN))
                   || (16'(n_pos) < n_plen);
        if (w_malformed) begin
            w_res.status = ST_MALFORMED;
        end else if (n_type != TYPE_REPLY) begin
            w_res.status = ST_NOT_REPLY;
        end else if (n_id != r_expected_id) begin
            w_res.status = ST_ID_BAD;
        end else if (w_sum_fin != CSUM_GOOD) begin
            w_res.status = ST_CSUM_BAD;
        end else begin
            w_res.status = ST_OK;
        end
        w_res.sequence_res = n_seq;
        w_res.ttl          = n_ttl;
        w_res.icmp_length  = (w_ilen > {4'd0, ILEN_MAX}) ? ILEN_MAX : w_ilen[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= 16'd0;
        end else if (i_cfg_we) begin
            r_expected_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || w_adv) begin
            r_in_valid <= i_in_valid;
        end
        if ((!r_in_valid || w_adv) && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_in.last_byte)) begin
            r_pos      <= '0;
            r_hdr      <= 6'd0;
            r_plen     <= 16'd0;
            r_ttl      <= 8'd0;
            r_type     <= 8'd0;
            r_id       <= 16'd0;
            r_seq      <= 16'd0;
            r_sum      <= 16'd0;
            r_hold     <= 8'd0;
            r_too_long <= 1'b0;
        end else if (w_proc) begin
            r_pos      <= n_pos;
            r_hdr      <= n_hdr;
            r_plen     <= n_plen;
            r_ttl      <= n_ttl;
            r_type     <= n_type;
            r_id       <= n_id;
            r_seq      <= n_seq;
            r_sum      <= n_sum;
            r_hold     <= n_hold;
            r_too_long <= n_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_proc && r_in.last_byte;
        end
        if (w_proc && r_in.last_byte) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/icmp_erc_checker.sv =====
// Port-level assertions for the ICMP echo reply checker, bound to its top level.
// Depends on icmp_erc_pkg and icmp_echo_reply_checker.
`default_nettype none

module icmp_erc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_stall,
    input icmp_erc_pkg::t_in_beat   i_in_beat,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input icmp_erc_pkg::t_out_beat  o_out_beat
);
    import icmp_erc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status == ST_OK |-> o_out_beat.icmp_length >= 12'd8)
        else $error("good verdict on a message shorter than the ICMP header");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid)
        |-> $past(i_in_valid && !o_in_stall && i_in_beat.last_byte, 2))
        else $error("result beat without an accepted last beat");

endmodule

bind icmp_echo_reply_checker icmp_erc_checker u_icmp_erc_checker (.*);

`default_nettype wire
